FILE: sv/assert_macros.svh
// shared assertion macros, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define HNG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define HNG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/hng_pkg.sv
package hng_pkg;

  localparam int unsigned DIM_W    = 11;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned SUMSQ_W  = 35;
  localparam int unsigned AV_W     = 18;
  localparam logic [AV_W-1:0] Y_VEC = 18'd131072;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd256;
  localparam logic [DIM_W-1:0] DIM_MIN   = 11'd2;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // top level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_SQ,
    ST_SUM,
    ST_NGO,
    ST_NWAIT,
    ST_OUT
  } hng_state_t;

  // normal component being normalized
  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_t;

  // normalizer phases for one trial bit
  typedef enum logic [1:0] {
    NP_IDLE,
    NP_T2,
    NP_MUL,
    NP_CMP
  } norm_phase_t;

endpackage

FILE: sv/hng_if.sv
// height sample channel
interface hng_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] height_sample;
  modport source (output valid, mode, height_sample, input ready);
  modport sink (input valid, mode, height_sample, output ready);
endinterface

// vertex result channel
interface hng_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] pos_x_twice;
  logic signed [10:0] pos_z_twice;
  logic        [15:0] height_out;
  logic signed [15:0] normal_x;
  logic        [14:0] normal_y;
  logic signed [15:0] normal_z;
  logic               frame_end;
  modport source (output valid, pos_x_twice, pos_z_twice, height_out, normal_x,
                  normal_y, normal_z, frame_end, input ready);
  modport sink (input valid, pos_x_twice, pos_z_twice, height_out, normal_x,
                normal_y, normal_z, frame_end, output ready);
endinterface

// register write channel
interface hng_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/hng_ram.sv
module hng_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/hng_norm.sv
`include "assert_macros.svh"

module hng_norm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [hng_pkg::AV_W-1:0]        av,
  input  logic [hng_pkg::SUMSQ_W-1:0]     s,
  output logic                            done,
  output logic [hng_pkg::MAG_W-1:0]       mag
);
  import hng_pkg::*;

  norm_phase_t         phase_r, phase_nxt;
  logic [3:0]          k_r;
  logic [MAG_W-1:0]    m_r;
  logic [2*AV_W-1:0]   l_r;
  logic [SUMSQ_W-1:0]  s_r;
  logic [31:0]         t2_r;
  logic [49:0]         plo_r;
  logic [48:0]         phi_r;
  logic                done_r;
  logic [MAG_W-1:0]    trial;
  logic [15:0]         t;
  logic [67:0]         prod;
  logic [67:0]         lhs;
  logic                pass;

  // trial magnitude and its doubled lower rounding bound
  assign trial = m_r | (MAG_W'(1) << k_r);
  assign t     = {trial, 1'b0} - 16'd1;
  assign prod  = {1'b0, phi_r, 18'b0} + 68'(plo_r);
  assign lhs   = {2'b0, l_r, 30'b0};
  assign pass  = lhs >= prod;

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= NP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == NP_CMP) && (k_r == 4'd0);
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      NP_IDLE: if (start) phase_nxt = NP_T2;
      NP_T2:   phase_nxt = NP_MUL;
      NP_MUL:  phase_nxt = NP_CMP;
      NP_CMP:  phase_nxt = (k_r == 4'd0) ? NP_IDLE : NP_T2;
      default: phase_nxt = NP_IDLE;
    endcase
  end

  // greedy bit search, msb first, one multiply stage per cycle
  always_ff @(posedge clk) begin
    unique case (phase_r)
      NP_IDLE: begin
        if (start) begin
          l_r <= av * av;
          s_r <= s;
          m_r <= '0;
          k_r <= 4'(MAG_W - 1);
        end
      end
      NP_T2: t2_r <= t * t;
      NP_MUL: begin
        plo_r <= t2_r * s_r[17:0];
        phi_r <= t2_r * s_r[34:18];
      end
      NP_CMP: begin
        if (pass) m_r <= trial;
        if (k_r != 4'd0) k_r <= k_r - 4'd1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign mag  = m_r;

  `HNG_ASSERT_IMPL(a_mag_bound, done_r, m_r <= 15'd16384, "normal magnitude above one")
  `HNG_ASSERT_IMPL(a_done_idle, done_r, phase_r == NP_IDLE, "done outside idle phase")

endmodule

FILE: sv/heightmap_normal_generator_unit.sv
// Heightmap vertex generator. Height samples (Q0.16) enter in raster order; each
// sample from the second row on yields the vertex one row above it with its doubled
// centered position, height and a unit normal in Q1.14, and drain items
// (mode 1) then yield the last row, the final one flagged with frame_end. The block
// works on one item at a time: a first-row sample or an ignored item is taken while
// idle and leaves it idle, while an item that yields a vertex holds ready low from
// its transfer until the block is idle again. Such an item passes through the row
// store reads on the single read port of each store, the squares and their sum, the
// shared normalizer, which resolves each of the three components by a 15-bit search
// with a squaring, a multiply and a compare phase per bit, and the output load. A
// finished vertex waits in the output register while the next item is taken. Writing
// either register restarts the frame; stored rows are kept.
`include "assert_macros.svh"

module heightmap_normal_generator_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  hng_in_if.sink    in_ch,
  hng_out_if.source out_ch,
  hng_cfg_if.sink   cfg_ch
);
  import hng_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  hng_state_t       state_r, state_nxt;
  comp_t            comp_r;
  logic [DIM_W-1:0] eff_w_r, eff_h_r;
  logic [DIM_W-1:0] col_r, row_r, dcnt_r;
  logic             draining_r;
  logic [DIM_W-1:0] cfg_dim;
  logic             cfg_wr, accept, take_drain, take_smp, row0, start_seq;
  logic [DIM_W-1:0] sel_col;

  // per item latches
  logic [DIM_W-1:0] item_col_r, item_zrow_r;
  logic             item_drain_r, item_frame_r, item_xedge_r, item_zedge_r;
  logic [SMP_W-1:0] smp_r, hc_r, ocm1_r, ncp1_r, oc_r;
  logic signed [16:0] dx_r, dz_r;
  logic [SMP_W-1:0] ax_r, az_r;
  logic [31:0]      dx2_r, dz2_r;
  logic [SUMSQ_W-1:0] s_r;
  logic signed [15:0] nx_r, nz_r;
  logic [MAG_W-1:0]   ny_r;

  // output register
  logic             out_valid_r;
  logic signed [10:0] pos_x_r, pos_z_r;
  logic [SMP_W-1:0] height_r;
  logic signed [15:0] onx_r, onz_r;
  logic [MAG_W-1:0] ony_r;
  logic             ofe_r;
  logic             out_load;

  // row store ports
  logic             new_we, old_we;
  logic [AW-1:0]    new_waddr, old_waddr, new_raddr, old_raddr;
  logic [SMP_W-1:0] new_wdata, old_wdata, new_q, old_q;
  logic [AW-1:0]    a_c;

  // normalizer hookup
  logic             norm_start, norm_done;
  logic [AV_W-1:0]  norm_av;
  logic [MAG_W-1:0] norm_mag;
  logic [SMP_W-1:0] ax_c, az_c;
  logic [16:0]      dx_neg, dz_neg;
  logic             dx_pos, dz_pos;
  logic [15:0]      mag_ext;

  // handshakes
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign accept       = in_ch.valid && (state_r == ST_IDLE);
  assign take_drain   = in_ch.mode && draining_r;
  assign take_smp     = !in_ch.mode && !draining_r;
  assign row0         = take_smp && (row_r == '0);
  assign start_seq    = take_drain || (take_smp && (row_r != '0));
  assign sel_col      = take_drain ? dcnt_r : col_r;

  // clamp of a written dimension
  always_comb begin
    if (cfg_ch.data < DIM_MIN) begin
      cfg_dim = DIM_MIN;
    end else if (cfg_ch.index == CFG_GRID_WIDTH && 32'(cfg_ch.data) > MAX_WIDTH) begin
      cfg_dim = DIM_W'(MAX_WIDTH);
    end else if (cfg_ch.index == CFG_GRID_HEIGHT && 32'(cfg_ch.data) > MAX_HEIGHT) begin
      cfg_dim = DIM_W'(MAX_HEIGHT);
    end else begin
      cfg_dim = cfg_ch.data;
    end
  end

  // dimensions and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= DIM_RESET;
      eff_h_r    <= DIM_RESET;
      col_r      <= '0;
      row_r      <= '0;
      dcnt_r     <= '0;
      draining_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        CFG_GRID_WIDTH:  eff_w_r <= cfg_dim;
        CFG_GRID_HEIGHT: eff_h_r <= cfg_dim;
        default: ;
      endcase
      col_r      <= '0;
      row_r      <= '0;
      dcnt_r     <= '0;
      draining_r <= 1'b0;
    end else if (accept && take_drain) begin
      if (dcnt_r >= eff_w_r - 11'd1) begin
        draining_r <= 1'b0;
        dcnt_r     <= '0;
      end else begin
        dcnt_r <= dcnt_r + 11'd1;
      end
    end else if (accept && take_smp) begin
      if (col_r >= eff_w_r - 11'd1) begin
        col_r <= '0;
        if (row_r >= eff_h_r - 11'd1) begin
          row_r      <= '0;
          draining_r <= 1'b1;
          dcnt_r     <= '0;
        end else begin
          row_r <= row_r + 11'd1;
        end
      end else begin
        col_r <= col_r + 11'd1;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and normalizer start
  always_comb begin
    state_nxt  = state_r;
    norm_start = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (accept && start_seq) state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_NGO;
      ST_NGO: begin
        norm_start = 1'b1;
        state_nxt  = ST_NWAIT;
      end
      ST_NWAIT: if (norm_done) state_nxt = (comp_r == COMP_Z) ? ST_OUT : ST_NGO;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // row store addressing
  assign a_c = AW'(item_col_r);
  always_comb begin
    new_raddr = a_c;
    old_raddr = a_c - AW'(1);
    unique case (state_r)
      ST_RD1: begin
        new_raddr = a_c + AW'(1);
        old_raddr = a_c;
      end
      ST_RD2: new_raddr = a_c - AW'(1);
      default: ;
    endcase
  end

  // first-row samples go straight in; later samples shift rows after the reads
  always_comb begin
    new_we    = 1'b0;
    new_waddr = a_c;
    new_wdata = smp_r;
    old_we    = 1'b0;
    old_waddr = a_c;
    old_wdata = hc_r;
    if (state_r == ST_IDLE) begin
      new_we    = accept && row0;
      new_waddr = AW'(col_r);
      new_wdata = in_ch.height_sample;
    end else if (state_r == ST_RD3) begin
      new_we = !item_drain_r;
      old_we = !item_drain_r;
    end
  end

  hng_ram #(.DEPTH(MAX_WIDTH), .WIDTH(SMP_W)) u_newer (
    .clk(clk), .wr_en(new_we), .wr_addr(new_waddr), .wr_data(new_wdata),
    .rd_addr(new_raddr), .rd_data(new_q)
  );

  hng_ram #(.DEPTH(MAX_WIDTH), .WIDTH(SMP_W)) u_older (
    .clk(clk), .wr_en(old_we), .wr_addr(old_waddr), .wr_data(old_wdata),
    .rd_addr(old_raddr), .rd_data(old_q)
  );

  // magnitudes and signs of the differences
  assign dx_neg  = -dx_r;
  assign dz_neg  = -dz_r;
  assign ax_c    = dx_r[16] ? dx_neg[15:0] : dx_r[15:0];
  assign az_c    = dz_r[16] ? dz_neg[15:0] : dz_r[15:0];
  assign dx_pos  = !dx_r[16] && (dx_r != '0);
  assign dz_pos  = !dz_r[16] && (dz_r != '0);
  assign mag_ext = {1'b0, norm_mag};

  always_comb begin
    unique case (comp_r)
      COMP_X:  norm_av = AV_W'(ax_r);
      COMP_Y:  norm_av = Y_VEC;
      COMP_Z:  norm_av = AV_W'(az_r);
      default: norm_av = '0;
    endcase
  end

  hng_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(norm_start), .av(norm_av), .s(s_r),
    .done(norm_done), .mag(norm_mag)
  );

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_col_r   <= sel_col;
          item_drain_r <= in_ch.mode;
          item_zrow_r  <= take_drain ? eff_h_r - 11'd1 : row_r - 11'd1;
          item_frame_r <= take_drain && (dcnt_r == eff_w_r - 11'd1);
          item_xedge_r <= (sel_col == '0) || (sel_col == eff_w_r - 11'd1);
          item_zedge_r <= take_drain || (row_r == 11'd1);
          smp_r        <= in_ch.height_sample;
        end
      end
      ST_RD1: begin
        hc_r   <= new_q;
        ocm1_r <= old_q;
      end
      ST_RD2: begin
        ncp1_r <= new_q;
        oc_r   <= old_q;
      end
      ST_RD3: begin
        dx_r <= item_xedge_r ? '0 :
                $signed({1'b0, ncp1_r}) - $signed({1'b0, item_drain_r ? new_q : ocm1_r});
        dz_r <= item_zedge_r ? '0 : $signed({1'b0, smp_r}) - $signed({1'b0, oc_r});
      end
      ST_SQ: begin
        ax_r  <= ax_c;
        az_r  <= az_c;
        dx2_r <= ax_c * ax_c;
        dz2_r <= az_c * az_c;
      end
      ST_SUM: begin
        s_r    <= SUMSQ_W'(dx2_r) + SUMSQ_W'(dz2_r) + (SUMSQ_W'(1) << 34);
        comp_r <= COMP_X;
      end
      ST_NWAIT: begin
        if (norm_done) begin
          unique case (comp_r)
            COMP_X: begin
              nx_r   <= dx_pos ? -$signed(mag_ext) : $signed(mag_ext);
              comp_r <= COMP_Y;
            end
            COMP_Y: begin
              ny_r   <= norm_mag;
              comp_r <= COMP_Z;
            end
            COMP_Z:  nz_r <= dz_pos ? -$signed(mag_ext) : $signed(mag_ext);
            default: comp_r <= COMP_X;
          endcase
        end
      end
      default: ;
    endcase
  end

  // output register, loaded when empty or drained this cycle
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x_r  <= $signed({item_col_r[9:0], 1'b0} - eff_w_r);
      pos_z_r  <= $signed({item_zrow_r[9:0], 1'b0} - eff_h_r);
      height_r <= hc_r;
      onx_r    <= nx_r;
      ony_r    <= ny_r;
      onz_r    <= nz_r;
      ofe_r    <= item_frame_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x_twice = pos_x_r;
  assign out_ch.pos_z_twice = pos_z_r;
  assign out_ch.height_out  = height_r;
  assign out_ch.normal_x    = onx_r;
  assign out_ch.normal_y    = ony_r;
  assign out_ch.normal_z    = onz_r;
  assign out_ch.frame_end   = ofe_r;

  `HNG_ASSERT_IMPL(a_drain_col_rest, draining_r, col_r == '0, "column moved while draining")
  `HNG_ASSERT_ALWAYS(a_col_range, col_r < eff_w_r, "column count beyond grid width")
  `HNG_ASSERT_IMPL(a_done_wait, norm_done, state_r == ST_NWAIT, "normalizer done unexpected")

endmodule

FILE: tb/heightmap_normal_generator_unit_tb.sv
module heightmap_normal_generator_unit_tb;
  import hng_pkg::*;

  localparam int unsigned MAXW = 1024;
  localparam int unsigned MAXH = 1024;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam bit MODE_SAMPLE = 1'b0;
  localparam bit MODE_DRAIN = 1'b1;

  typedef struct {
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_z;
    logic [15:0] height;
    logic signed [15:0] nx;
    logic [14:0] ny;
    logic signed [15:0] nz;
    logic frame_end;
  } vertex_t;

  logic clk;
  logic rst_n;
  hng_in_if in_ch ();
  hng_out_if out_ch ();
  hng_cfg_if cfg_ch ();

  heightmap_normal_generator_unit #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // expected vertices and error count
  vertex_t expected_vertices[$];
  int unsigned errors = 0;
  int unsigned vertex_items = 0;
  int unsigned hold_cycles = 0;
  int unsigned burst_left = 0;
  longint unsigned cycles = 0;

  // predictor state
  logic [15:0] older_row[0:MAXW-1];
  logic [15:0] newer_row[0:MAXW-1];
  int unsigned width_reg, height_reg;
  int unsigned row_idx, col_idx, drain_idx;
  bit draining;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // known input values from the start
  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_SAMPLE;
    in_ch.height_sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_GRID_WIDTH;
    cfg_ch.data <= '0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL heightmap_normal_generator_unit");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // rounded 16384*av/sqrt(s), exact integer search
  function automatic logic [14:0] unit_mag(input longint unsigned av,
                                           input longint unsigned s);
    logic [127:0] lhs, rhs;
    int unsigned lo, hi, mid;
    longint unsigned t;
    lhs = 128'(av * av) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * longint'(mid) - 1;
      rhs = 128'(t * t) * 128'(s);
      if (lhs >= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 15'(lo);
  endfunction

  task automatic push_vertex(input int unsigned col, input int unsigned row,
                             input int unsigned w, input int unsigned h,
                             input logic [15:0] ht, input longint dx, input longint dz,
                             input bit last);
    vertex_t v;
    longint unsigned s;
    logic [14:0] m;
    s = longint'(dx * dx) + longint'(dz * dz) + (64'd1 << 34);
    v.pos_x = 11'(2 * col - w);
    v.pos_z = 11'(2 * row - h);
    v.height = ht;
    m = unit_mag(dx < 0 ? -dx : dx, s);
    v.nx = (dx > 0) ? 16'(17'h10000 - m) : {1'b0, m};
    v.ny = unit_mag(131072, s);
    m = unit_mag(dz < 0 ? -dz : dz, s);
    v.nz = (dz > 0) ? 16'(17'h10000 - m) : {1'b0, m};
    v.frame_end = last;
    expected_vertices.push_back(v);
  endtask

  // register write seen by the predictor
  task automatic predict_cfg(input cfg_reg_t idx, input int unsigned value);
    if (idx == CFG_GRID_WIDTH) width_reg = value & 11'h7ff;
    else height_reg = value & 11'h7ff;
    row_idx = 0;
    col_idx = 0;
    drain_idx = 0;
    draining = 0;
  endtask

  // one accepted item seen by the predictor
  task automatic predict_item(input bit mode, input logic [15:0] smp);
    int unsigned w, h, c, r, d;
    longint dx, dz;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    dx = 0;
    dz = 0;
    if (mode == MODE_DRAIN) begin
      if (draining) begin
        d = (drain_idx >= w) ? w - 1 : drain_idx;
        if (d != 0 && d != w - 1)
          dx = longint'(newer_row[d + 1]) - longint'(newer_row[d - 1]);
        push_vertex(d, h - 1, w, h, newer_row[d], dx, 0, d == w - 1);
        vertex_items++;
        if (d >= w - 1) begin
          draining = 0;
          drain_idx = 0;
        end else begin
          drain_idx = d + 1;
        end
      end
    end else if (!draining) begin
      c = (col_idx >= w) ? w - 1 : col_idx;
      r = (row_idx >= h) ? h - 1 : row_idx;
      if (r == 0) begin
        newer_row[c] = smp;
      end else begin
        if (c != 0 && c != w - 1)
          dx = longint'(newer_row[c + 1]) - longint'(older_row[c - 1]);
        if (r - 1 != 0) dz = longint'(smp) - longint'(older_row[c]);
        push_vertex(c, r - 1, w, h, newer_row[c], dx, dz, 1'b0);
        vertex_items++;
        older_row[c] = newer_row[c];
        newer_row[c] = smp;
      end
      if (c >= w - 1) begin
        col_idx = 0;
        if (r >= h - 1) begin
          row_idx = 0;
          draining = 1;
          drain_idx = 0;
        end else begin
          row_idx = r + 1;
        end
      end else begin
        col_idx = c + 1;
      end
    end
  endtask

  // offer one item, bursts with random gaps
  task automatic send_item(input bit mode, input logic [15:0] smp);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.height_sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(mode, smp);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  // wait until every expected vertex has arrived, then let the block settle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both dimension registers back to back
  task automatic write_dims(input int unsigned w_raw, input int unsigned h_raw);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_GRID_WIDTH;
    cfg_ch.data <= 11'(w_raw);
    do @(posedge clk); while (!cfg_ch.ready);
    predict_cfg(CFG_GRID_WIDTH, w_raw);
    cfg_ch.index <= CFG_GRID_HEIGHT;
    cfg_ch.data <= 11'(h_raw);
    do @(posedge clk); while (!cfg_ch.ready);
    predict_cfg(CFG_GRID_HEIGHT, h_raw);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_height(input int unsigned style);
    case ($urandom_range(0, 3))
      0: return (style == 0) ? 16'h0000 : 16'(32768 + $urandom_range(0, 64));
      1: return (style == 0) ? 16'hffff : 16'(32768 - $urandom_range(0, 64));
      default: return (style == 0) ? 16'($urandom) : 16'(32768 + $urandom_range(0, 2000));
    endcase
  endfunction

  // one frame of w x h samples then its drain, with optional noise and an optional early cut
  task automatic run_frame(input int unsigned w, input int unsigned h, input bit noisy,
                           input bit truncate);
    int unsigned n, cut, style;
    style = $urandom_range(0, 1);
    cut = truncate ? $urandom_range(1, w * h + w - 1) : w * h + w;
    for (n = 0; n < w * h && n < cut; n++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(MODE_DRAIN, 16'($urandom));
      send_item(MODE_SAMPLE, pick_height(style));
    end
    if (noisy && $urandom_range(0, 2) == 0) send_item(MODE_SAMPLE, 16'($urandom));
    for (n = w * h; n < w * h + w && n < cut; n++) send_item(MODE_DRAIN, 16'($urandom));
    if (noisy && $urandom_range(0, 2) == 0) send_item(MODE_DRAIN, 16'($urandom));
  endtask

  // receiver: stall pattern, long hold on request, compare each transfer
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_vertices.size() == 0) begin
          report("unexpected vertex pos_x", out_ch.pos_x_twice, 0);
        end else begin
          e = expected_vertices.pop_front();
          if (out_ch.pos_x_twice !== e.pos_x) report("pos_x", out_ch.pos_x_twice, e.pos_x);
          if (out_ch.pos_z_twice !== e.pos_z) report("pos_z", out_ch.pos_z_twice, e.pos_z);
          if (out_ch.height_out !== e.height) report("height", out_ch.height_out, e.height);
          if (out_ch.normal_x !== e.nx) report("normal_x", out_ch.normal_x, e.nx);
          if (out_ch.normal_y !== e.ny) report("normal_y", out_ch.normal_y, e.ny);
          if (out_ch.normal_z !== e.nz) report("normal_z", out_ch.normal_z, e.nz);
          if (out_ch.frame_end !== e.frame_end)
            report("frame_end", out_ch.frame_end, e.frame_end);
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 600);
      end else begin
        rx_left--;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // first-row samples at reset dimensions, stray drain
  task automatic test_reset_defaults();
    send_item(MODE_SAMPLE, 16'h0000);
    send_item(MODE_SAMPLE, 16'hffff);
    send_item(MODE_SAMPLE, 16'h1234);
    send_item(MODE_DRAIN, 16'h0000);
  endtask

  // 3x3 frame of extreme heights, ignored items around the drain
  task automatic test_small_extremes();
    logic [15:0] grid[0:8];
    int unsigned i;
    grid = '{16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff,
             16'h0000, 16'hffff, 16'hffff};
    write_dims(3, 3);
    for (i = 0; i < 9; i++) send_item(MODE_SAMPLE, grid[i]);
    send_item(MODE_SAMPLE, 16'hffff);
    for (i = 0; i < 3; i++) send_item(MODE_DRAIN, 16'hffff);
    send_item(MODE_DRAIN, 16'h0000);
  endtask

  // dimensions below range clamp to 2
  task automatic test_clamp_minimum();
    write_dims(1, 0);
    send_item(MODE_SAMPLE, 16'hffff);
    send_item(MODE_SAMPLE, 16'h0000);
    send_item(MODE_SAMPLE, 16'h8000);
    send_item(MODE_SAMPLE, 16'h7fff);
    send_item(MODE_DRAIN, 16'h0000);
    send_item(MODE_DRAIN, 16'h0000);
  endtask

  // width above range clamps down, start of the widest row
  task automatic test_max_width();
    int unsigned i;
    write_dims(1500, 2);
    for (i = 0; i < 40; i++) send_item(MODE_SAMPLE, 16'($urandom));
  endtask

  // tallest map, all-ones register value clamps down, first hundred rows
  task automatic test_max_height();
    int unsigned i, style;
    style = $urandom_range(0, 1);
    write_dims(2047, 1);
    write_dims(1, 2047);
    for (i = 0; i < 200; i++) send_item(MODE_SAMPLE, pick_height(style));
  endtask

  // random small frames, some noisy or cut short, one under backpressure
  task automatic test_random_frames();
    int unsigned start, w, h, k;
    start = vertex_items;
    k = 0;
    while (vertex_items - start < 300) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      write_dims(w, h);
      if (k == 3) hold_cycles = 1500;
      run_frame(w, h, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      k++;
    end
  endtask

  initial begin
    width_reg = DIM_RESET;
    height_reg = DIM_RESET;
    row_idx = 0;
    col_idx = 0;
    drain_idx = 0;
    draining = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_small_extremes();
    test_clamp_minimum();
    test_max_width();
    test_max_height();
    test_random_frames();
    settle();
    if (errors == 0 && expected_vertices.size() == 0) begin
      $display("PASS heightmap_normal_generator_unit");
    end else begin
      $display("FAIL heightmap_normal_generator_unit");
    end
    $finish;
  end

endmodule

FILE: heightmap_normal_generator_unit.f
+incdir+sv
sv/hng_pkg.sv
sv/hng_if.sv
sv/hng_ram.sv
sv/hng_norm.sv
sv/heightmap_normal_generator_unit.sv
tb/heightmap_normal_generator_unit_tb.sv
